// File: src/fpbs_pkg.sv
// Package with shared constants, types and the multiplier control struct.
`default_nettype none
package fpbs_pkg;
    localparam int unsigned EXPONENT_WIDTH_DEF = 63;
    localparam logic [63:0] ONE_BITS = 64'h3FF0000000000000;
    localparam logic [63:0] CANON_NAN = 64'h7FF8000000000000;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;
endpackage
`default_nettype wire

// File: src/fpbs_mul.sv
// Multicycle IEEE-754 binary64 multiplier, round to nearest even, shared by the sequencer.
`default_nettype none
module fpbs_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fpbs_pkg::t_mul_req i_req,
    output fpbs_pkg::t_mul_rsp     o_rsp
);
    import fpbs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PP   = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_SHFT = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]   r_state, n_state;
    logic         r_sign;
    logic         r_special;
    logic [63:0]  r_spec_val;
    logic [52:0]  r_ma, r_mb;
    logic signed [13:0] r_exp;
    logic [105:0] r_prod;
    logic [1:0]   r_pp_idx;
    logic [6:0]   r_shift;
    logic [63:0]  r_res;

    // Operand unpacking.
    logic [10:0] ea, eb;
    logic [51:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [5:0]  lza, lzb;
    logic [52:0] ma_n, mb_n;
    logic signed [13:0] exa, exb;

    function automatic logic [5:0] lz53(input logic [52:0] v);
        logic [5:0] c;
        logic       f;
        c = 6'd0;
        f = 1'b0;
        for (int k = 52; k >= 0; k--) begin
            if (!f && v[k]) begin
                f = 1'b1;
            end else if (!f) begin
                c = c + 6'd1;
            end
        end
        return c;
    endfunction

    always_comb begin
        ea = i_req.a[62:52];
        eb = i_req.b[62:52];
        fa = i_req.a[51:0];
        fb = i_req.b[51:0];
        a_nan = (ea == 11'h7FF) && (fa != 52'd0);
        b_nan = (eb == 11'h7FF) && (fb != 52'd0);
        a_inf = (ea == 11'h7FF) && (fa == 52'd0);
        b_inf = (eb == 11'h7FF) && (fb == 52'd0);
        a_zero = (ea == 11'd0) && (fa == 52'd0);
        b_zero = (eb == 11'd0) && (fb == 52'd0);
        ma_n = {(ea != 11'd0), fa};
        mb_n = {(eb != 11'd0), fb};
        lza = lz53(ma_n);
        lzb = lz53(mb_n);
        exa = (ea == 11'd0) ? 14'sd1 : $signed({3'd0, ea});
        exb = (eb == 11'd0) ? 14'sd1 : $signed({3'd0, eb});
    end

    // One 27x27 partial product per cycle, four partial products in all.
    logic [26:0] pa_lo, pa_hi;
    logic [25:0] pb_hi;
    logic [26:0] pb_lo;
    logic [53:0] pp;
    logic [105:0] pp_sh;
    always_comb begin
        pa_lo = r_ma[26:0];
        pa_hi = {1'b0, r_ma[52:27]};
        pb_lo = r_mb[26:0];
        pb_hi = r_mb[52:27];
        pp_sh = 106'd0;
        pp = 54'd0;
        case (r_pp_idx)
            2'd0: begin
                pp = pa_lo * pb_lo;
                pp_sh = {52'd0, pp};
            end
            2'd1: begin
                pp = pa_lo * {1'b0, pb_hi};
                pp_sh = {25'd0, pp, 27'd0};
            end
            2'd2: begin
                pp = pa_hi * pb_lo;
                pp_sh = {25'd0, pp, 27'd0};
            end
            default: begin
                pp = pa_hi * {1'b0, pb_hi};
                pp_sh = {pp[51:0], 54'd0};
            end
        endcase
    end

    // Normalization: product in [1,4) once operands are normalized.
    // Biased exponent of bit 104 position is r_exp; shift right for underflow.
    logic [107:0] sh_in, sh_out;
    logic         sticky_sh;
    always_comb begin
        sh_in = {r_prod, 2'b00};
        sh_out = sh_in >> r_shift;
        sticky_sh = 1'b0;
        for (int k = 0; k < 108; k++) begin
            if (k < r_shift && sh_in[k]) begin
                sticky_sh = 1'b1;
            end
        end
    end

    // Rounding: r_prod[104:52] holds the 53-bit significand, bit 51 guard.
    logic        g, st, lsb, inc;
    logic [53:0] mr;
    logic signed [13:0] er;
    logic [63:0] rnd_val;
    always_comb begin
        g = r_prod[51];
        st = |r_prod[50:0];
        lsb = r_prod[52];
        inc = g && (st || lsb);
        mr = {1'b0, r_prod[104:52]} + {53'd0, inc};
        er = r_exp;
        if (mr[53]) begin
            er = r_exp + 14'sd1;
        end
        if (er >= 14'sd2047) begin
            rnd_val = {r_sign, 11'h7FF, 52'd0};
        end else if (mr[53]) begin
            rnd_val = {r_sign, er[10:0], 52'd0};
        end else if (!mr[52]) begin
            rnd_val = {r_sign, 11'd0, mr[51:0]};
        end else begin
            rnd_val = {r_sign, er[10:0], mr[51:0]};
        end
    end

    function automatic logic r_special_n();
        return a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.start) n_state = r_special_n() ? S_DONE : S_PP;
            S_PP:   if (r_pp_idx == 2'd3) n_state = S_NORM;
            S_NORM: n_state = S_SHFT;
            S_SHFT: n_state = S_RND;
            S_RND:  n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sign <= i_req.a[63] ^ i_req.b[63];
                r_special <= r_special_n();
                if (a_nan || b_nan || ((a_inf || b_inf) && (a_zero || b_zero))) begin
                    r_spec_val <= CANON_NAN;
                end else if (a_inf || b_inf) begin
                    r_spec_val <= {i_req.a[63] ^ i_req.b[63], 11'h7FF, 52'd0};
                end else begin
                    r_spec_val <= {i_req.a[63] ^ i_req.b[63], 63'd0};
                end
                r_ma <= ma_n << lza;
                r_mb <= mb_n << lzb;
                // Biased exponent of a product whose leading bit is at 104.
                r_exp <= exa - $signed({8'd0, lza}) + exb - $signed({8'd0, lzb})
                         - 14'sd1023;
                r_prod <= 106'd0;
                r_pp_idx <= 2'd0;
            end
            S_PP: begin
                r_prod <= r_prod + pp_sh;
                r_pp_idx <= r_pp_idx + 2'd1;
            end
            S_NORM: begin
                if (r_prod[105]) begin
                    r_prod <= {1'b0, r_prod[105:2], |r_prod[1:0]};
                    r_exp <= r_exp + 14'sd1;
                end else begin
                    r_prod <= {r_prod[104:0], 1'b0} >> 1;
                end
                r_shift <= 7'd0;
                if (r_exp + (r_prod[105] ? 14'sd1 : 14'sd0) < 14'sd1) begin
                    if ((14'sd1 - r_exp - (r_prod[105] ? 14'sd1 : 14'sd0)) > 14'sd107) begin
                        r_shift <= 7'd107;
                    end else begin
                        r_shift <= 7'(14'sd1 - r_exp - (r_prod[105] ? 14'sd1 : 14'sd0));
                    end
                end
            end
            S_SHFT: begin
                // The shifted significand sits at the minimum normal exponent.
                if (r_shift != 7'd0) begin
                    r_prod <= {sh_out[107:3], sh_out[2] | sh_out[1] | sh_out[0] | sticky_sh};
                    r_exp <= 14'sd1;
                end
            end
            S_RND: begin
                r_res <= r_special ? r_spec_val : rnd_val;
            end
            default: begin
            end
        endcase
        if (r_state == S_IDLE && r_special_n()) begin
            r_res <= (a_nan || b_nan || ((a_inf || b_inf) && (a_zero || b_zero)))
                     ? CANON_NAN
                     : ((a_inf || b_inf) ? {i_req.a[63] ^ i_req.b[63], 11'h7FF, 52'd0}
                                         : {i_req.a[63] ^ i_req.b[63], 63'd0});
        end
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.p = r_res;
endmodule
`default_nettype wire

// File: src/float_power_by_squaring_unit.sv
// Top level: square-and-multiply sequencer around one shared double multiplier.
// Raises an IEEE-754 double base to an unsigned integer power.
// Input channel: i_valid / o_stall with i_base_bits and i_exponent; a transfer
// happens when valid is high and stall is low. The unit holds o_stall high
// from the accepted transfer until its result has been taken.
// Output channel: o_valid / i_stall with o_power_bits; the result stays
// stable while i_stall is high.
// Sequence: the exponent is scanned bit by bit down to its top set bit, which
// takes one multiply; each lower bit then takes one squaring and, for a one
// bit, one multiply as well, all in the shared multiplier, which takes a
// shorter path for special operands. Exponent zero skips the multiplier.
// Throughput: one item at a time; the next is taken after the result leaves.
// Reset: synchronous, active low; returns to idle with no result pending.
`default_nettype none
module float_power_by_squaring_unit #(
    parameter int unsigned EXPONENT_WIDTH = fpbs_pkg::EXPONENT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_base_bits,
    input  wire logic [62:0] i_exponent,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_power_bits
);
    import fpbs_pkg::*;

    localparam int unsigned IW = (EXPONENT_WIDTH > 1) ? $clog2(EXPONENT_WIDTH) : 1;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [EXPONENT_WIDTH-1:0] r_exp;
    logic [IW-1:0] r_idx;
    logic [63:0] r_base, r_acc;
    logic        r_busy;
    t_mul_req    mreq;
    t_mul_rsp    mrsp;

    fpbs_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mreq),
        .o_rsp  (mrsp)
    );

    logic cur_bit;
    assign cur_bit = r_exp[r_idx];

    always_comb begin
        mreq.start = 1'b0;
        mreq.a = r_acc;
        mreq.b = r_acc;
        if (r_state == S_SQ && !r_busy) begin
            mreq.start = 1'b1;
        end else if (r_state == S_MUL && !r_busy) begin
            mreq.start = 1'b1;
            mreq.b = r_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SCAN;
                        r_exp <= i_exponent[EXPONENT_WIDTH-1:0];
                        r_base <= i_base_bits;
                        r_acc <= ONE_BITS;
                        r_idx <= IW'(EXPONENT_WIDTH - 1);
                    end
                end
                S_SCAN: begin
                    if (cur_bit) begin
                        // Squaring 1.0 is exact, so the first set bit goes to the multiply.
                        r_state <= S_MUL;
                    end else if (r_idx == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_SQ: begin
                    if (!r_busy) begin
                        r_busy <= 1'b1;
                    end else if (mrsp.done) begin
                        r_busy <= 1'b0;
                        r_acc <= mrsp.p;
                        r_state <= cur_bit ? S_MUL : ((r_idx == '0) ? S_OUT : S_SQ);
                        if (!cur_bit && r_idx != '0) begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    if (!r_busy) begin
                        r_busy <= 1'b1;
                    end else if (mrsp.done) begin
                        r_busy <= 1'b0;
                        r_acc <= mrsp.p;
                        if (r_idx == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign n_state = r_state;
    assign o_stall = (n_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_power_bits = r_acc;
endmodule
`default_nettype wire

// File: test/tb_float_power_by_squaring_unit.sv
// Self-checking testbench for the double-precision power-by-squaring unit.
`default_nettype none
module tb_float_power_by_squaring_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fpbs_pkg::*;

    localparam int unsigned EXP_W = EXPONENT_WIDTH_DEF;
    localparam int unsigned N_RANDOM = 1430;
    localparam int unsigned IDLE_LIMIT = 30000;
    localparam int unsigned DRAIN_CYCLES = 1500;

    localparam logic [63:0] EXP_MASK = 64'h7FF0000000000000;
    localparam logic [63:0] FRAC_MASK = 64'h000FFFFFFFFFFFFF;

    // Holds the powers that are still owed by the unit, oldest first.
    class power_scoreboard;
        logic [63:0] owed_powers[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // Square-and-multiply from the top set bit, each multiply rounded to double.
        function logic [63:0] raise_power(logic [63:0] base_bits, logic [62:0] expo);
            real base_val;
            real acc;
            logic [63:0] res;
            bit started;
            base_val = $bitstoreal(base_bits);
            acc = 1.0;
            started = 0;
            for (int i = EXP_W - 1; i >= 0; i--) begin
                if (started || expo[i]) begin
                    started = 1;
                    acc = acc * acc;
                    if (expo[i]) acc = acc * base_val;
                end
            end
            res = $realtobits(acc);
            if ((res & EXP_MASK) == EXP_MASK && (res & FRAC_MASK) != 0) res = CANON_NAN;
            return res;
        endfunction

        function void note_operand(logic [63:0] base_bits, logic [62:0] expo);
            owed_powers.push_back(raise_power(base_bits, expo));
        endfunction

        function void check_power(logic [63:0] actual);
            logic [63:0] want;
            if (owed_powers.size() == 0) begin
                $display("%0t: unexpected result %h", $time, actual);
                errors++;
            end else begin
                want = owed_powers.pop_front();
                if (want !== actual) begin
                    $display("%0t: power_bits mismatch expected %h actual %h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_base_bits;
    logic [62:0] i_exponent;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_power_bits;

    power_scoreboard sb;
    int unsigned idle_cycles;
    int unsigned burst_left;
    int unsigned stall_phase;
    bit          running;

    float_power_by_squaring_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_base_bits (i_base_bits),
        .i_exponent  (i_exponent),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_power_bits(o_power_bits)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Result side: check each transfer and stall on a pattern that changes phase.
    always @(posedge i_clk) begin
        if (running && o_valid && !i_stall) sb.check_power(o_power_bits);
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 300) % 4)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 1);
            2: i_stall <= ((stall_phase % 16) < 11);
            default: i_stall <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!running || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("float_power_by_squaring_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_operand(input logic [63:0] base_bits, input logic [62:0] expo);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_base_bits <= base_bits;
        i_exponent <= expo;
        do @(posedge i_clk); while (o_stall);
        sb.note_operand(base_bits, expo);
    endtask

    task automatic wait_all_returned();
        i_valid <= 1'b0;
        while (sb.owed_powers.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    function automatic logic [63:0] pick_base();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: b[62:52] = $urandom_range(0, 1) ? 11'h3FF : 11'h3FE;
            4, 5: b[62:52] = 11'(($urandom_range(0, 63)) + 11'h3E0);
            6, 7: ;
            8: b[51:0] = 52'($urandom_range(0, 3));
            default: begin
                case ($urandom_range(0, 5))
                    0: b = 64'h0;
                    1: b = 64'h7FF0000000000000;
                    2: b = {1'b0, 11'h7FF, b[51:1], 1'b1};
                    3: b = {b[63], 11'h0, b[51:0]};
                    4: b = {b[63], ONE_BITS[62:0]};
                    default: b = {b[63], 11'h400, 52'h0};
                endcase
            end
        endcase
        return b;
    endfunction

    function automatic logic [62:0] pick_exponent();
        logic [62:0] e;
        case ($urandom_range(0, 19))
            0, 1: e = 63'({$urandom, $urandom});
            2: e = 63'(1) << $urandom_range(0, 62);
            3, 4, 5, 6: e = 63'($urandom_range(0, 65535));
            7: e = 63'($urandom_range(0, 2047));
            default: e = 63'($urandom_range(0, 40));
        endcase
        return e;
    endfunction

    initial begin
        sb = new();
        running = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        stall_phase = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_base_bits = '0;
        i_exponent = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        // Zero power of any base, a NaN base included, must be one; then special and edge bases.
        send_operand(64'hFFF0000000000123, 63'd0);
        send_operand(64'h0000000000000000, 63'd0);
        send_operand(64'hFFFFFFFFFFFFFFFF, 63'd1);
        send_operand(64'h3FF0000000000000, {63{1'b1}});
        send_operand(64'hBFF0000000000000, {63{1'b1}});
        send_operand(64'h8000000000000000, 63'd3);
        send_operand(64'h8000000000000000, 63'd2);
        send_operand(64'hFFF0000000000000, 63'd5);
        send_operand(64'hFFF0000000000000, 63'd4);
        send_operand(64'h0000000000000001, 63'd1);
        send_operand(64'h0000000000000001, 63'd2);
        send_operand(64'h7FEFFFFFFFFFFFFF, 63'd1);
        send_operand(64'h7FEFFFFFFFFFFFFF, 63'd2);
        // Overflow, gradual underflow into subnormals, and underflow to zero, then long exponent patterns.
        send_operand(64'h4000000000000000, 63'd1100);
        send_operand(64'h3FE0000000000000, 63'd1060);
        send_operand(64'hBFE0000000000000, 63'd1073);
        send_operand(64'hBFE0000000000000, 63'd1101);
        send_operand(64'h3FF0000000000001, 63'h4000000000000000);
        send_operand(64'h3FF0000000000001, 63'h2AAAAAAAAAAAAAAA);
        send_operand(64'h3FEFFFFFFFFFFFFF, 63'h5555555555555555);
        send_operand(64'hBFF8000000000000, 63'd37);
        send_operand(64'h3FB999999999999A, 63'd300);

        wait_all_returned();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) wait_all_returned();
            send_operand(pick_base(), pick_exponent());
        end
        i_valid <= 1'b0;

        while (sb.owed_powers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("float_power_by_squaring_unit regression: pass");
        end else begin
            $display("float_power_by_squaring_unit regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
